FILE: rtl/core/rgb_median3x3_filter_core_defines.svh
// Assertion macros shared by the median filter core.
`ifndef RGB_MEDIAN3X3_FILTER_CORE_DEFINES_SVH
`define RGB_MEDIAN3X3_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RGBMED_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RGBMED_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rgbmed_pkg.sv
package rgbmed_pkg;

    // Default frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    // Request kinds on the pixel channel
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Pixel and window geometry
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = 4 * CH_W;
    localparam int SMP_W    = NUM_CH * CH_W;
    localparam int WIN_SIDE = 3;
    localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
    localparam int RANK_W   = $clog2(WIN_N + 1);

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 4);

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [2*PIX_W-1:0] t_line;

    typedef struct packed {
        logic                        valid;
        logic [WIN_N-1:0][SMP_W-1:0] smp;
        logic [WIN_N-1:0]            mask;
        logic [CH_W-1:0]             alpha;
        logic                        last;
    } t_med_req;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            frame_last;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_res_push;

    typedef struct packed {
        logic c_vld;
        logic d_vld;
    } t_med_stat;

endpackage

FILE: rtl/core/rgbmed_ifs.sv
// Pixel request channel
interface rgbmed_pix_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, output action, output in_red, output in_green,
                    output in_blue, output in_alpha, input ready);
    modport sink   (input valid, input action, input in_red, input in_green,
                    input in_blue, input in_alpha, output ready);
endinterface

// Result channel
interface rgbmed_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input frame_last, output ready);
endinterface

// Configuration write channel
interface rgbmed_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rgbmed_pkg::CFG_IDX_W-1:0]    index;
    logic [rgbmed_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rgbmed_line_store.sv
module rgbmed_line_store #(
    parameter int  DEPTH = rgbmed_pkg::MAX_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  rgbmed_pkg::t_line i_wr_data,
    output rgbmed_pkg::t_line o_rd_data
);

    rgbmed_pkg::t_line r_mem [DEPTH];
    rgbmed_pkg::t_line r_q;
    rgbmed_pkg::t_line r_fwd_data;
    logic              r_fwd_hit;

    // Write one column entry, read one column entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Flag a read that collides with the write of the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    // Take the fresh entry over the stale memory word
    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule

FILE: rtl/core/rgbmed_median.sv
module rgbmed_median (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbmed_pkg::t_med_req  i_req,
    output rgbmed_pkg::t_res_push o_push,
    output rgbmed_pkg::t_med_stat o_stat
);

    localparam int CH_W   = rgbmed_pkg::CH_W;
    localparam int NUM_CH = rgbmed_pkg::NUM_CH;
    localparam int WIN_N  = rgbmed_pkg::WIN_N;
    localparam int SMP_W  = rgbmed_pkg::SMP_W;
    localparam int RANK_W = rgbmed_pkg::RANK_W;

    // Window stage
    logic                        r_c_vld;
    logic [WIN_N-1:0][SMP_W-1:0] r_c_smp;
    logic [WIN_N-1:0]            r_c_mask;
    logic [CH_W-1:0]             r_c_alpha;
    logic                        r_c_last;

    // Rank stage
    logic                                    r_d_vld;
    logic [WIN_N-1:0][SMP_W-1:0]             r_d_smp;
    logic [WIN_N-1:0]                        r_d_mask;
    logic [NUM_CH-1:0][WIN_N-1:0][RANK_W-1:0] r_d_rank;
    logic [RANK_W-1:0]                       r_d_k;
    logic [CH_W-1:0]                         r_d_alpha;
    logic                                    r_d_last;

    logic [NUM_CH-1:0][WIN_N-1:0][RANK_W-1:0] n_rank;
    logic [RANK_W-1:0]                       n_k;
    logic [NUM_CH-1:0][CH_W-1:0]             v_med;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_c_vld <= i_req.valid;
            r_d_vld <= r_c_vld;
        end
    end

    // Hold window and rank payloads
    always_ff @(posedge i_clk) begin
        r_c_smp   <= i_req.smp;
        r_c_mask  <= i_req.mask;
        r_c_alpha <= i_req.alpha;
        r_c_last  <= i_req.last;
        r_d_smp   <= r_c_smp;
        r_d_mask  <= r_c_mask;
        r_d_rank  <= n_rank;
        r_d_k     <= n_k;
        r_d_alpha <= r_c_alpha;
        r_d_last  <= r_c_last;
    end

    // Rank each valid sample; ties break by window position
    always_comb begin
        logic [CH_W-1:0]   v_si;
        logic [CH_W-1:0]   v_sj;
        logic [RANK_W-1:0] v_acc;
        logic [RANK_W-1:0] v_n;
        n_rank = '0;
        v_si   = '0;
        v_sj   = '0;
        v_acc  = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int i = 0; i < WIN_N; i++) begin
                v_acc = '0;
                v_si  = r_c_smp[i][ch*CH_W +: CH_W];
                for (int j = 0; j < WIN_N; j++) begin
                    v_sj = r_c_smp[j][ch*CH_W +: CH_W];
                    if ((j != i) && r_c_mask[j] &&
                        ((v_sj < v_si) || ((v_sj == v_si) && (j < i)))) begin
                        v_acc = v_acc + RANK_W'(1);
                    end
                end
                n_rank[ch][i] = v_acc;
            end
        end
        v_n = '0;
        for (int i = 0; i < WIN_N; i++) begin
            v_n = v_n + RANK_W'(r_c_mask[i]);
        end
        n_k = v_n >> 1;
    end

    // Pick the sample whose rank is the middle one
    always_comb begin
        v_med = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int i = 0; i < WIN_N; i++) begin
                if (r_d_mask[i] && (r_d_rank[ch][i] == r_d_k)) begin
                    v_med[ch] = v_med[ch] | r_d_smp[i][ch*CH_W +: CH_W];
                end
            end
        end
    end

    assign o_push.valid          = r_d_vld;
    assign o_push.res.out_red    = v_med[0];
    assign o_push.res.out_green  = v_med[1];
    assign o_push.res.out_blue   = v_med[2];
    assign o_push.res.out_alpha  = r_d_alpha;
    assign o_push.res.frame_last = r_d_last;

    assign o_stat.c_vld = r_c_vld;
    assign o_stat.d_vld = r_d_vld;

endmodule

FILE: rtl/core/rgbmed_res_fifo.sv
module rgbmed_res_fifo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rgbmed_pkg::t_res_push                i_push,
    rgbmed_res_if.source                         o_res,
    output logic [rgbmed_pkg::FIFO_CNT_W-1:0]    o_count
);

    localparam int DEPTH = rgbmed_pkg::FIFO_DEPTH;
    localparam int PW    = rgbmed_pkg::FIFO_PTR_W;
    localparam int CNTW  = rgbmed_pkg::FIFO_CNT_W;

    rgbmed_pkg::t_res r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_cnt;
    logic             v_pop;

    assign v_pop = o_res.valid && o_res.ready;

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (v_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push.valid && !v_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (!i_push.valid && v_pop) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    // Present the oldest result
    assign o_res.valid      = (r_cnt != '0);
    assign o_res.out_red    = r_mem[r_rd_ptr].out_red;
    assign o_res.out_green  = r_mem[r_rd_ptr].out_green;
    assign o_res.out_blue   = r_mem[r_rd_ptr].out_blue;
    assign o_res.out_alpha  = r_mem[r_rd_ptr].out_alpha;
    assign o_res.frame_last = r_mem[r_rd_ptr].frame_last;
    assign o_count          = r_cnt;

endmodule

FILE: rtl/core/rgb_median3x3_filter_core.sv
// Release: the result for a pixel is due one row plus one pixel of requests later and passes
// the column, window and rank registers and the result queue once released. Throughput: one
// request per cycle while the queue has room for all work in flight, set by one column read
// and one write-back of the line store per request; an 8-entry queue absorbs output stalls.
// Reset: frame size returns to 640 x 480, counters and window clear; line store is not cleared.
`include "rgb_median3x3_filter_core_defines.svh"

module rgb_median3x3_filter_core #(
    parameter int MAX_WIDTH  = rgbmed_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbmed_pkg::MAX_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgbmed_cfg_if.sink   i_cfg,
    rgbmed_pix_if.sink   i_pix,
    rgbmed_res_if.source o_res
);

    localparam int CFG_W = rgbmed_pkg::CFG_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int OW    = $clog2(MAX_HEIGHT);
    localparam int XW    = (EW > CFG_W) ? EW : CFG_W;
    localparam int YW    = (EH > CFG_W) ? EH : CFG_W;
    localparam int OCC_W = rgbmed_pkg::OCC_W;
    localparam int SIDE  = rgbmed_pkg::WIN_SIDE;
    localparam int SMP_W = rgbmed_pkg::SMP_W;
    localparam int CH_W  = rgbmed_pkg::CH_W;

    // Configuration
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             v_cfg_hit;
    logic [EW-1:0]    v_eff_w;
    logic [EH-1:0]    v_eff_h;

    // Position counters
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [OW-1:0] r_out_row;
    logic [CW-1:0] n_in_col;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] n_out_col;
    logic [OW-1:0] n_out_row;

    // Request decode
    logic              v_accept;
    logic              v_row_live;
    logic              v_ignore;
    logic              v_take;
    logic              v_prod;
    logic              v_pre;
    logic              v_last;
    logic [EW-1:0]     v_col_inc;
    logic [EW-1:0]     v_out_inc;
    logic [EH-1:0]     v_row_inc;
    logic [SIDE-1:0]   v_cmask;
    logic [SIDE-1:0]   v_rmask;
    rgbmed_pkg::t_pix  v_pix;

    // Column stage
    logic              r_b_vld;
    rgbmed_pkg::t_pix  r_b_pix;
    logic [CW-1:0]     r_b_col;
    logic              r_b_prod;
    logic              r_b_pre;
    logic              r_b_last;
    logic [SIDE-1:0]   r_b_cmask;
    logic [SIDE-1:0]   r_b_rmask;
    rgbmed_pkg::t_pix  r_win [SIDE][SIDE];
    rgbmed_pkg::t_line v_rd_line;
    rgbmed_pkg::t_pix  v_top;
    rgbmed_pkg::t_pix  v_mid;
    rgbmed_pkg::t_pix  v_right [SIDE];

    rgbmed_pkg::t_med_req  v_med_req;
    rgbmed_pkg::t_res_push v_push;
    rgbmed_pkg::t_med_stat v_med_stat;
    logic [rgbmed_pkg::FIFO_CNT_W-1:0] v_fifo_cnt;
    logic [OCC_W-1:0]      v_occ;

    // Clamp the frame size into the supported range
    always_comb begin
        if (r_frame_width == '0) begin
            v_eff_w = EW'(1);
        end else if (XW'(r_frame_width) > XW'(MAX_WIDTH)) begin
            v_eff_w = EW'(MAX_WIDTH);
        end else begin
            v_eff_w = EW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            v_eff_h = EH'(1);
        end else if (YW'(r_frame_height) > YW'(MAX_HEIGHT)) begin
            v_eff_h = EH'(MAX_HEIGHT);
        end else begin
            v_eff_h = EH'(r_frame_height);
        end
    end

    // Accept configuration at any time
    assign i_cfg.ready = 1'b1;
    assign v_cfg_hit   = i_cfg.valid &&
                         ((i_cfg.index == rgbmed_pkg::CFG_FRAME_WIDTH) ||
                          (i_cfg.index == rgbmed_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rgbmed_pkg::FRAME_WIDTH_RST;
            r_frame_height <= rgbmed_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rgbmed_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                rgbmed_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Admit a request while the result queue has room for everything in flight
    assign v_occ = OCC_W'(v_fifo_cnt) + OCC_W'(r_b_vld) + OCC_W'(v_med_stat.c_vld)
                 + OCC_W'(v_med_stat.d_vld);
    assign i_pix.ready = (v_occ < OCC_W'(rgbmed_pkg::FIFO_DEPTH));
    assign v_accept    = i_pix.valid && i_pix.ready;

    // Decode the request against the current positions
    always_comb begin
        v_row_live = (RW'(v_eff_h) > r_in_row);
        v_ignore   = (i_pix.action == rgbmed_pkg::ACT_DRAIN) && v_row_live;
        v_take     = v_accept && !v_ignore;
        v_col_inc  = EW'(r_in_col) + EW'(1);
        v_out_inc  = EW'(r_out_col) + EW'(1);
        v_row_inc  = EH'(r_out_row) + EH'(1);
        v_prod     = ((r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0)))
                     && (EH'(r_out_row) < v_eff_h);
        v_pre      = v_prod && (r_in_col == '0);
        v_last     = (v_out_inc == v_eff_w) && (v_row_inc == v_eff_h);
        v_cmask    = {v_out_inc < v_eff_w, 1'b1, r_out_col != '0};
        v_rmask    = {v_row_inc < v_eff_h, 1'b1, r_out_row != '0};
        if (v_row_live) begin
            v_pix = {i_pix.in_alpha, i_pix.in_blue, i_pix.in_green, i_pix.in_red};
        end else begin
            v_pix = '0;
        end
    end

    // Step the input and output positions
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (v_cfg_hit) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (v_take) begin
            if (v_col_inc >= v_eff_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = CW'(v_col_inc);
            end
            if (v_prod) begin
                if (v_out_inc >= v_eff_w) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OW'(1);
                end else begin
                    n_out_col = CW'(v_out_inc);
                end
            end
            if (v_prod && v_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_b_vld   <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_b_vld   <= v_take;
        end
    end

    // Hold the decoded request for the column stage
    always_ff @(posedge i_clk) begin
        r_b_pix   <= v_pix;
        r_b_col   <= r_in_col;
        r_b_prod  <= v_prod;
        r_b_pre   <= v_pre;
        r_b_last  <= v_last;
        r_b_cmask <= v_cmask;
        r_b_rmask <= v_rmask;
    end

    // Read the column at accept, write it back in the next cycle
    rgbmed_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (v_take),
        .i_rd_addr (r_in_col),
        .i_wr_en   (r_b_vld),
        .i_wr_addr (r_b_col),
        .i_wr_data ({r_b_pix, v_mid}),
        .o_rd_data (v_rd_line)
    );

    assign v_top = v_rd_line[rgbmed_pkg::PIX_W-1:0];
    assign v_mid = v_rd_line[2*rgbmed_pkg::PIX_W-1:rgbmed_pkg::PIX_W];

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < SIDE; c++) begin
                for (int r = 0; r < SIDE; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (r_b_vld) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= v_top;
            r_win[2][1] <= v_mid;
            r_win[2][2] <= r_b_pix;
        end
    end

    // At a row start the right column repeats the last one of the previous row
    always_comb begin
        if (r_b_pre) begin
            v_right[0] = r_win[2][0];
            v_right[1] = r_win[2][1];
            v_right[2] = r_win[2][2];
        end else begin
            v_right[0] = v_top;
            v_right[1] = v_mid;
            v_right[2] = r_b_pix;
        end
    end

    // Build the median request from the window
    always_comb begin
        v_med_req.valid = r_b_vld && r_b_prod;
        v_med_req.alpha = r_win[2][1][rgbmed_pkg::PIX_W-1 -: CH_W];
        v_med_req.last  = r_b_last;
        for (int r = 0; r < SIDE; r++) begin
            v_med_req.smp[r]          = r_win[1][r][SMP_W-1:0];
            v_med_req.smp[SIDE + r]   = r_win[2][r][SMP_W-1:0];
            v_med_req.smp[2*SIDE + r] = v_right[r][SMP_W-1:0];
            v_med_req.mask[r]          = r_b_cmask[0] && r_b_rmask[r];
            v_med_req.mask[SIDE + r]   = r_b_cmask[1] && r_b_rmask[r];
            v_med_req.mask[2*SIDE + r] = r_b_cmask[2] && r_b_rmask[r];
        end
    end

    rgbmed_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (v_med_req),
        .o_push  (v_push),
        .o_stat  (v_med_stat)
    );

    rgbmed_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (v_push),
        .o_res   (o_res),
        .o_count (v_fifo_cnt)
    );

    // Queue plus work in flight never exceeds the queue depth
    `RGBMED_CHECK(a_occ_bound, i_clk, i_rst_n, 1'b1, v_occ <= OCC_W'(rgbmed_pkg::FIFO_DEPTH), "result queue overcommitted")
    // A taken request reaches the column stage on the next cycle
    `RGBMED_CHECK_NEXT(a_take_enters, i_clk, i_rst_n, v_take, r_b_vld, "taken request lost before column stage")
    // The output position stays inside the frame
    `RGBMED_CHECK(a_out_pos, i_clk, i_rst_n, 1'b1, (EW'(r_out_col) < v_eff_w) && (EH'(r_out_row) < v_eff_h), "output position outside frame")

endmodule

FILE: tb/testbench.sv
module testbench;
    import rgbmed_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 640;
    localparam int EXTREME_PIXELS = 40;
    localparam int LINE_DEPTH     = MAX_WIDTH_DEF;

    // Indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Predicts filtered pixels from accepted requests and checks the result stream
    class median_scoreboard;
        typedef t_pix window_t [3][3];

        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_pix             line_mem [2*LINE_DEPTH];
        t_pix             taps [3][3];
        int               in_col, in_row, out_col, out_row;
        t_res             medians_due [$];
        int               errors;
        bit               frame_closed;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (taps[c, r]) taps[c][r] = '0;
            restart();
            errors       = 0;
            frame_closed = 0;
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int clamp_dim(logic [CFG_W-1:0] v, int lim);
            if (v == 0) return 1;
            if (v > lim) return lim;
            return int'(v);
        endfunction

        function int eff_width();
            return clamp_dim(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int eff_height();
            return clamp_dim(height_reg, MAX_HEIGHT_DEF);
        endfunction

        function int frame_pixels();
            return eff_width() * eff_height();
        endfunction

        function int pending();
            return medians_due.size();
        endfunction

        // Any write to a real register restarts the frame; stored pixels stay
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = val;
                restart();
            end else if (idx == CFG_FRAME_HEIGHT) begin
                height_reg = val;
                restart();
            end
        endfunction

        // Rank count/2 of one channel over the in-frame part of the window
        function logic [CH_W-1:0] channel_median(window_t cols, int w, int h, int ch);
            logic [CH_W-1:0] s [WIN_N];
            logic [CH_W-1:0] t;
            int n, x, y, c, r, i, j;
            n = 0;
            for (c = 0; c < 3; c++) begin
                x = out_col + c - 1;
                if (x < 0 || x >= w) continue;
                for (r = 0; r < 3; r++) begin
                    y = out_row + r - 1;
                    if (y < 0 || y >= h) continue;
                    s[n] = cols[c][r][ch*CH_W +: CH_W];
                    n++;
                end
            end
            for (i = 0; i < n; i++) begin
                for (j = i + 1; j < n; j++) begin
                    if (s[i] > s[j]) begin
                        t    = s[i];
                        s[i] = s[j];
                        s[j] = t;
                    end
                end
            end
            return (n > 0) ? s[n/2] : '0;
        endfunction

        function t_res filtered_pixel(window_t cols, int w, int h);
            t_res r;
            r.out_red    = channel_median(cols, w, h, 0);
            r.out_green  = channel_median(cols, w, h, 1);
            r.out_blue   = channel_median(cols, w, h, 2);
            r.out_alpha  = cols[1][1][PIX_W-1 -: CH_W];
            r.frame_last = (out_col == w - 1) && (out_row == h - 1);
            return r;
        endfunction

        function void note_request(logic act, t_pix rgba);
            window_t cols;
            t_res    res;
            t_pix    pix, top, mid;
            int      w, h, col, c;
            bit      due;
            w = eff_width();
            h = eff_height();
            // drop drains while the frame is still coming in
            if (act == ACT_DRAIN && in_row < h) return;
            pix = (in_row >= h) ? '0 : rgba;
            col = (in_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : in_col;
            due = (in_row >= 2 || (in_row == 1 && in_col >= 1)) && out_row < h;

            // row wrap: last column sees the unshifted window plus a phantom column
            if (due && in_col == 0) begin
                for (c = 0; c < 3; c++) begin
                    cols[0][c] = taps[1][c];
                    cols[1][c] = taps[2][c];
                    cols[2][c] = taps[2][c];
                end
                res = filtered_pixel(cols, w, h);
            end

            // advance line store and window
            top = line_mem[col];
            mid = line_mem[LINE_DEPTH + col];
            line_mem[col]              = mid;
            line_mem[LINE_DEPTH + col] = pix;
            taps[0]    = taps[1];
            taps[1]    = taps[2];
            taps[2][0] = top;
            taps[2][1] = mid;
            taps[2][2] = pix;

            if (due && in_col != 0) res = filtered_pixel(taps, w, h);

            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end

            if (due) begin
                medians_due.push_back(res);
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
                if (res.frame_last) begin
                    restart();
                    frame_closed = 1;
                end
            end
        endfunction

        function void compare_field(string label, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (medians_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = medians_due.pop_front();
            compare_field("out_red", want.out_red, got.out_red);
            compare_field("out_green", want.out_green, got.out_green);
            compare_field("out_blue", want.out_blue, got.out_blue);
            compare_field("out_alpha", want.out_alpha, got.out_alpha);
            compare_field("frame_last", CH_W'(want.frame_last), CH_W'(got.frame_last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   quiet_cycles;
    t_res res_seen;

    rgbmed_cfg_if cfg_if ();
    rgbmed_pix_if pix_if ();
    rgbmed_res_if res_if ();

    median_scoreboard sb = new();

    rgb_median3x3_filter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    assign res_seen = {res_if.out_red, res_if.out_green, res_if.out_blue,
                       res_if.out_alpha, res_if.frame_last};

    always #HALF_PERIOD i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Full random, heavy ties, or channels at the extremes
    function automatic t_pix random_pixel();
        t_pix p;
        int   k;
        p = $urandom;
        case ($urandom_range(0, 3))
            1: for (k = 0; k < 4; k++) p[k*CH_W +: CH_W] = CH_W'($urandom_range(0, 3));
            2: for (k = 0; k < 4; k++) p[k*CH_W +: CH_W] = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: ;
        endcase
        return p;
    endfunction

    // Check accepted results and stall the result side at random
    always @(posedge i_clk) begin
        int stall_left;
        if (res_if.valid && res_if.ready) sb.check_result(res_seen);
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Abort if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val, bit last);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
        if (last) cfg_if.valid <= 1'b0;
    endtask

    task automatic setup_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w, 1'b0);
        write_reg(CFG_FRAME_HEIGHT, h, 1'b1);
    endtask

    task automatic send_pixel(logic act, t_pix rgba);
        int gap;
        pix_if.valid  <= 1'b1;
        pix_if.action <= act;
        {pix_if.in_alpha, pix_if.in_blue, pix_if.in_green, pix_if.in_red} <= rgba;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_request(act, rgba);
        // hold valid through back-to-back requests, drop it for a gap
        if (!steady && $urandom_range(0, 9) < 4) begin
            gap = gap_len();
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drain until the last pixel of the frame has been released
    task automatic finish_frame();
        while (!sb.frame_closed)
            send_pixel(($urandom_range(0, 1) == 1) ? ACT_DRAIN : ACT_PUSH, random_pixel());
        sb.frame_closed = 0;
    endtask

    task automatic run_frame(int noise_pct, output int pushed);
        int i;
        pushed = sb.frame_pixels();
        for (i = 0; i < pushed; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_pixel(ACT_DRAIN, random_pixel());
            send_pixel(ACT_PUSH, random_pixel());
        end
        finish_frame();
    endtask

    task automatic run_directed();
        t_pix corners [9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hFF00_FF00,
                              32'h8080_8080, 32'h7F7F_7F7F, 32'h0101_0101, 32'hFEFE_FEFE,
                              32'h5555_AAAA};
        int i;

        // zero sizes count as one pixel; drain early, drain with nothing due, late push
        setup_frame('0, '0);
        send_pixel(ACT_DRAIN, 32'hFFFF_FFFF);
        send_pixel(ACT_PUSH, 32'h00FF_FFFF);
        send_pixel(ACT_DRAIN, 32'h0000_0000);
        send_pixel(ACT_PUSH, 32'hA5A5_A5A5);
        finish_frame();
        wait_idle();

        // 3x3 of extreme values; spare register indexes must not restart the frame
        setup_frame(11'd3, 11'd3);
        send_pixel(ACT_PUSH, corners[0]);
        send_pixel(ACT_PUSH, corners[1]);
        wait_idle();
        write_reg(CFG_SPARE_LO, '1, 1'b0);
        write_reg(CFG_SPARE_HI, 11'h2AA, 1'b1);
        for (i = 2; i < 9; i++) begin
            if (i == 5) send_pixel(ACT_DRAIN, 32'hFFFF_FFFF);
            send_pixel(ACT_PUSH, corners[i]);
        end
        finish_frame();
        wait_idle();

        // a register write part way through the first row restarts the frame
        setup_frame(11'd2, 11'd2);
        send_pixel(ACT_PUSH, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 11'd2, 1'b1);
        for (i = 0; i < 4; i++) send_pixel(ACT_PUSH, corners[i + 4]);
        finish_frame();
        wait_idle();
    endtask

    // Oversized registers clamp; run the start of such frames and restart
    task automatic run_extremes();
        int i;
        setup_frame('1, 11'd2);
        for (i = 0; i < EXTREME_PIXELS; i++) send_pixel(ACT_PUSH, random_pixel());
        wait_idle();
        setup_frame(11'd1, '1);
        for (i = 0; i < EXTREME_PIXELS; i++) send_pixel(ACT_PUSH, random_pixel());
        wait_idle();
        setup_frame(11'd4, 11'd3);
    endtask

    task automatic run_random();
        int pushed, n, roll, w, h, cut, i;
        pushed = 0;
        while (pushed < RANDOM_PIXELS) begin
            steady = ($urandom_range(0, 4) == 0);

            // pick a new frame size between frames
            if ($urandom_range(0, 9) < 7) begin
                roll = $urandom_range(0, 99);
                w = (roll < 70) ? $urandom_range(1, 6) : (roll < 90) ? $urandom_range(7, 40)
                  : (roll < 95) ? 0 : $urandom_range(41, 96);
                roll = $urandom_range(0, 99);
                h = (roll < 75) ? $urandom_range(1, 5) : (roll < 95) ? $urandom_range(6, 12) : 0;
                wait_idle();
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_FRAME_WIDTH, CFG_W'(w), 1'b1);
                    1: write_reg(CFG_FRAME_HEIGHT, CFG_W'(h), 1'b1);
                    default: setup_frame(CFG_W'(w), CFG_W'(h));
                endcase
            end

            // broken frame: cut short within the first row and restart
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, sb.eff_width());
                for (i = 0; i < cut; i++) send_pixel(ACT_PUSH, random_pixel());
                wait_idle();
                if ($urandom_range(0, 1) == 1) write_reg(CFG_FRAME_WIDTH, sb.width_reg, 1'b1);
                else write_reg(CFG_FRAME_HEIGHT, sb.height_reg, 1'b1);
            end

            run_frame(($urandom_range(0, 2) == 0) ? 10 : 0, n);
            pushed += n;
        end
        steady = 0;
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        steady        = 0;
        quiet_cycles  = 0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_FRAME_WIDTH;
        cfg_if.data   = '0;
        pix_if.valid  = 1'b0;
        pix_if.action = ACT_PUSH;
        pix_if.in_red   = '0;
        pix_if.in_green = '0;
        pix_if.in_blue  = '0;
        pix_if.in_alpha = '0;
        res_if.ready  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_extremes();
        run_random();
        wait_idle();

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: rgb_median3x3_filter_core.f
+incdir+rtl/core
rtl/core/rgbmed_pkg.sv
rtl/core/rgbmed_ifs.sv
rtl/core/rgbmed_line_store.sv
rtl/core/rgbmed_median.sv
rtl/core/rgbmed_res_fifo.sv
rtl/core/rgb_median3x3_filter_core.sv
tb/testbench.sv
